/* rtl/grc_pkg.sv */
// shared types and constants for the grouped range classifier
// no dependencies; imported by the classifier unit and its testbench
package grc_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = SLOT_W + 1;

    localparam int BOUND_W = 16;
    localparam int GROUP_W = 8;
    localparam int PROBE_W = 32;
    localparam int SLOTF_W = 6;
    localparam int MODE_W  = 2;

    // one table entry: {group, high, low}
    localparam int ENTRY_W = GROUP_W + 2 * BOUND_W;

    // input tdata layout, lowest field first
    localparam int IN_DATA_W = 80;
    localparam int SLOT_LSB  = 0;
    localparam int LOW_LSB   = SLOT_LSB + SLOTF_W;
    localparam int HIGH_LSB  = LOW_LSB + BOUND_W;
    localparam int TAG_LSB   = HIGH_LSB + BOUND_W;
    localparam int PROBE_LSB = TAG_LSB + GROUP_W;

    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

/* rtl/grc_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no package dependencies
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/grouped_range_classifier_unit.sv */
// grouped range classifier: range table with smallest-group lookup
// depends on grc_pkg and grc_ram
// write and clear beats are applied when accepted; a query scans the table one
// slot per cycle through the ram read port; one beat is in flight at a time,
// ready again once the result sits in the output register; synchronous
// active-low reset clears the per-slot valid bits, so the table comes up empty
// without a clearing pass
module grouped_range_classifier_unit
    import grc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: slot[5:0], range_low[21:6], range_high[37:22], group_tag[45:38],
    //        probe[77:46], zero pad[79:78]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [MODE_W-1:0]    s_axis_tuser,
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata: group_found[7:0]
    output logic [GROUP_W-1:0]   m_axis_tdata
);

    // ---------------------------------------------------------------------
    // input field unpacking
    // ---------------------------------------------------------------------
    logic [SLOTF_W-1:0]        in_slot;
    logic [BOUND_W-1:0]        in_low;
    logic [BOUND_W-1:0]        in_high;
    logic [GROUP_W-1:0]        in_tag;
    logic signed [PROBE_W-1:0] in_probe;
    logic [10:0]               slot_ext;
    logic                      slot_ok;

    assign in_slot  = s_axis_tdata[SLOT_LSB  +: SLOTF_W];
    assign in_low   = s_axis_tdata[LOW_LSB   +: BOUND_W];
    assign in_high  = s_axis_tdata[HIGH_LSB  +: BOUND_W];
    assign in_tag   = s_axis_tdata[TAG_LSB   +: GROUP_W];
    assign in_probe = s_axis_tdata[PROBE_LSB +: PROBE_W];

    // slot number widened so any table size can be indexed and checked
    assign slot_ext = 11'(in_slot);
    assign slot_ok  = (slot_ext < 11'(SLOTS));

    // ---------------------------------------------------------------------
    // state
    // ---------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [SLOTS-1:0]          r_valid, n_valid;     // slot written since clear
    logic [CNT_W-1:0]          r_idx, n_idx;         // next slot to read
    logic                      r_pend, n_pend;       // ram data due this cycle
    logic                      r_pend_v, n_pend_v;   // valid bit of that slot
    logic [GROUP_W-1:0]        r_best, n_best;       // running smallest group
    logic signed [PROBE_W-1:0] r_probe, n_probe;     // value being classified
    logic                      r_out_v, n_out_v;
    logic [GROUP_W-1:0]        r_out, n_out;

    // table ram signals
    logic                      ram_we;
    logic [SLOT_W-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]        ram_wdata;
    logic [SLOT_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]        ram_rdata;

    // shared compare unit: one entry against the probe per cycle
    logic [GROUP_W-1:0]        ent_group;
    logic signed [PROBE_W-1:0] ent_low;
    logic signed [PROBE_W-1:0] ent_high;
    logic                      ent_hit;
    logic                      in_beat;
    logic                      out_free;

    assign ent_group = ram_rdata[2*BOUND_W +: GROUP_W];
    assign ent_low   = {{(PROBE_W-BOUND_W){ram_rdata[BOUND_W-1]}},
                        ram_rdata[BOUND_W-1:0]};
    assign ent_high  = {{(PROBE_W-BOUND_W){ram_rdata[2*BOUND_W-1]}},
                        ram_rdata[BOUND_W +: BOUND_W]};
    assign ent_hit   = r_pend && r_pend_v && (ent_group != '0)
                       && (r_probe >= ent_low) && (r_probe <= ent_high);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_v || m_axis_tready;

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

    // write port driven straight from an accepted write beat
    assign ram_we    = in_beat && (s_axis_tuser == MODE_WRITE) && slot_ok;
    assign ram_waddr = slot_ext[SLOT_W-1:0];
    assign ram_wdata = {in_tag, in_high, in_low};
    assign ram_raddr = r_idx[SLOT_W-1:0];

    grc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // sequencer: next state and datapath control
    // ---------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_idx    = r_idx;
        n_pend   = 1'b0;
        n_pend_v = 1'b0;
        n_best   = r_best;
        n_probe  = r_probe;
        n_out_v  = r_out_v;
        n_out    = r_out;

        // result taken downstream
        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    case (s_axis_tuser)
                        MODE_QUERY: begin
                            n_probe = in_probe;
                            n_idx   = '0;
                            n_best  = '0;
                            n_state = ST_SCAN;
                        end
                        MODE_WRITE: begin
                            if (slot_ok) begin
                                n_valid[slot_ext[SLOT_W-1:0]] = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            n_valid = '0;
                        end
                        default: begin
                            // unused mode, dropped
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next read while the previous entry is compared
                if (r_idx < CNT_W'(SLOTS)) begin
                    n_pend   = 1'b1;
                    n_pend_v = r_valid[r_idx[SLOT_W-1:0]];
                    n_idx    = r_idx + 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                end
                if (ent_hit && ((r_best == '0) || (ent_group < r_best))) begin
                    n_best = ent_group;
                end
            end
            ST_DONE: begin
                // wait for room in the output register
                if (out_free) begin
                    n_out_v = 1'b1;
                    n_out   = r_best;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_pend  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_out_v <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pend_v <= n_pend_v;
        r_best   <= n_best;
        r_probe  <= n_probe;
        r_out    <= n_out;
    end

endmodule

/* verif/tb_grouped_range_classifier_unit.sv */
// testbench for grouped_range_classifier_unit: directed and random beats checked
// against a scoreboard that mirrors the range table; depends on grc_pkg and the rtl
module tb_grouped_range_classifier_unit
    import grc_pkg::*;
();

    // mode 3 has no meaning, the block drops it
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int RANDOM_ITEMS = 1680;
    localparam int PRESSURE_AT = 150;
    localparam int PRESSURE_HOLD = 400;

    // input fields, packed lowest field last so slot lands in the low bits
    typedef struct packed {
        logic signed [PROBE_W-1:0] probe;
        logic [GROUP_W-1:0]        group_tag;
        logic signed [BOUND_W-1:0] range_high;
        logic signed [BOUND_W-1:0] range_low;
        logic [SLOTF_W-1:0]        slot;
    } t_item_fields;

    // mirror of the range table plus the queue of groups still owed by the block
    class range_group_scoreboard;
        logic signed [BOUND_W-1:0] low_of [SLOTS];
        logic signed [BOUND_W-1:0] high_of [SLOTS];
        logic [GROUP_W-1:0]        group_of [SLOTS];
        logic [GROUP_W-1:0]        owed_groups [$];
        int unsigned               errors;

        function new();
            foreach (group_of[i]) begin
                low_of[i] = '0;
                high_of[i] = '0;
                group_of[i] = '0;
            end
            errors = 0;
        endfunction

        // smallest group among occupied slots whose range holds the value
        function logic [GROUP_W-1:0] smallest_group(logic signed [PROBE_W-1:0] value);
            logic [GROUP_W-1:0] best;
            best = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (group_of[i] != '0 && value >= low_of[i] && value <= high_of[i]
                        && (best == '0 || group_of[i] < best))
                    best = group_of[i];
            end
            return best;
        endfunction

        function void note_beat(logic [MODE_W-1:0] mode, t_item_fields f);
            case (mode)
                MODE_QUERY: owed_groups.push_back(smallest_group(f.probe));
                MODE_WRITE: begin
                    if (f.slot < SLOTS) begin
                        low_of[f.slot] = f.range_low;
                        high_of[f.slot] = f.range_high;
                        group_of[f.slot] = f.group_tag;
                    end
                end
                MODE_CLEAR: begin
                    foreach (group_of[i]) group_of[i] = '0;
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(logic [GROUP_W-1:0] got);
            logic [GROUP_W-1:0] want;
            if (owed_groups.size() == 0) begin
                report($sformatf("group_found %0d with no query outstanding", got));
            end else begin
                want = owed_groups.pop_front();
                if (got !== want)
                    report($sformatf("group_found %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: slot, range_low, range_high, group_tag, probe, zero pad
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    // tuser: mode
    logic [MODE_W-1:0]    s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: group_found
    logic [GROUP_W-1:0]   m_axis_tdata;

    range_group_scoreboard sb = new();
    bit sender_calm = 1'b0;

    grouped_range_classifier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // unused fields carry random bits, the block must ignore them
    function automatic t_item_fields random_fields();
        t_item_fields f;
        f.slot = SLOTF_W'($urandom);
        f.range_low = BOUND_W'($urandom);
        f.range_high = BOUND_W'($urandom);
        f.group_tag = GROUP_W'($urandom);
        f.probe = $urandom;
        return f;
    endfunction

    // offer one beat after an optional gap, hold it until the block takes it
    task automatic send_beat(input logic [MODE_W-1:0] mode, input t_item_fields f);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - $bits(t_item_fields)){1'b0}}, f};
        s_axis_tuser <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(mode, f);
    endtask

    task automatic do_query(input logic signed [PROBE_W-1:0] probe);
        t_item_fields f;
        f = random_fields();
        f.probe = probe;
        send_beat(MODE_QUERY, f);
    endtask

    task automatic do_write(input int slot, input int lo, input int hi, input int tag);
        t_item_fields f;
        f = random_fields();
        f.slot = SLOTF_W'(slot);
        f.range_low = BOUND_W'(lo);
        f.range_high = BOUND_W'(hi);
        f.group_tag = GROUP_W'(tag);
        send_beat(MODE_WRITE, f);
    endtask

    task automatic do_other(input logic [MODE_W-1:0] mode);
        send_beat(mode, random_fields());
    endtask

    // probes cluster around stored bounds so the edges of ranges get hit
    function automatic logic signed [PROBE_W-1:0] pick_probe();
        int r;
        int s;
        int base;
        logic signed [BOUND_W-1:0] h;
        r = $urandom_range(99);
        s = $urandom_range(SLOTS - 1);
        if (r < 45) begin
            base = $urandom_range(1) ? int'(sb.low_of[s]) : int'(sb.high_of[s]);
            return base + int'($urandom_range(4)) - 2;
        end
        if (r < 70) begin
            h = BOUND_W'($urandom);
            return PROBE_W'(h);
        end
        if (r < 85)
            return $urandom;
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return -32769;
            3: return 32768;
            4: return 32'h8000_0000;
            5: return 32'h7fff_ffff;
            6: return -1;
            default: return 0;
        endcase
    endfunction

    // mostly small overlapping ranges with small tags so the minimum matters
    task automatic random_write();
        int r;
        int lo;
        int hi;
        int tag;
        logic signed [BOUND_W-1:0] h;
        r = $urandom_range(99);
        if (r < 70) begin
            lo = int'($urandom_range(4000)) - 2000;
            hi = lo + int'($urandom_range(600));
        end else if (r < 85) begin
            h = BOUND_W'($urandom);
            lo = int'(h);
            h = BOUND_W'($urandom);
            hi = int'(h);
        end else if (r < 92) begin
            // inverted range
            lo = int'($urandom_range(2000)) - 1000;
            hi = lo - int'($urandom_range(50, 1));
        end else begin
            lo = $urandom_range(1) ? -32768 : -1;
            hi = $urandom_range(1) ? 32767 : -1;
        end
        r = $urandom_range(99);
        if (r < 10)
            tag = 0;
        else if (r < 18)
            tag = 255;
        else if (r < 80)
            tag = $urandom_range(12, 1);
        else
            tag = $urandom_range(254, 1);
        do_write($urandom_range(SLOTS - 1), lo, hi, tag);
    endtask

    // result side: checks every beat and stalls at random, once for a long stretch
    initial begin
        int stall_left;
        int calm_left;
        int results_seen;
        bit pressure_done;
        stall_left = 0;
        calm_left = 0;
        results_seen = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                results_seen++;
            end
            if (!pressure_done && results_seen == PRESSURE_AT && i_rst_n) begin
                // long hold while the sender keeps offering, input must back up
                pressure_done = 1'b1;
                stall_left = PRESSURE_HOLD;
            end else if (stall_left == 0) begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(999) < 3)
                    calm_left = 300;
                else if ($urandom_range(99) < 30)
                    stall_left = pick_gap();
            end
            if (stall_left > 0 || !i_rst_n) begin
                if (stall_left > 0)
                    stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        int issued;
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset answers zero everywhere
        do_query(0);
        do_query(32'h7fff_ffff);
        do_query(32'h8000_0000);

        // widest range, probed at and just past the 16-bit edges
        do_write(0, -32768, 32767, 200);
        do_query(-32768);
        do_query(32767);
        do_query(-32769);
        do_query(32768);
        do_query(32'h8000_0000);

        // minus one as a bound, in the last slot
        do_write(SLOTS - 1, -1, -1, 5);
        do_query(-1);
        do_query(0);

        // inverted range never matches
        do_write(10, 5, -5, 1);
        do_query(0);

        // emptying write keeps bounds but frees the slot
        do_write(SLOTS - 1, -1, -1, 0);
        do_query(-1);

        // overlapping ranges, smallest group wins
        do_write(20, 100, 200, 255);
        do_write(21, 150, 160, 3);
        do_query(155);
        do_query(161);

        // unused mode, then clear empties every slot
        do_other(MODE_NONE);
        do_other(MODE_CLEAR);
        do_query(155);
        do_query(-32768);

        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            if (issued % 150 == 149)
                sender_calm = !sender_calm && ($urandom_range(1) == 1);
            r = $urandom_range(999);
            if (r < 15) begin
                do_other(MODE_NONE);
            end else begin
                issued++;
                if (r < 25)
                    do_other(MODE_CLEAR);
                else if (r < 400)
                    random_write();
                else
                    do_query(pick_probe());
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.owed_groups.size() != 0) @(posedge i_clk);
        // room for a stray result after the last query
        repeat (SLOTS + 16) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
